[rtl/epst_pkg.sv]
// ----------------------------------------------------------------------------
// epst_pkg: shared types and constants of the encoder position/speed tracker
// Field widths, register indexes, reset values and the counter fold helper.
// ----------------------------------------------------------------------------
package epst_pkg;

   // hardware counter width and its half range
   localparam int CNT_BITS       = 16;
   localparam int CNT_HALF_INT   = 1 << (CNT_BITS - 1);
   localparam int MAG_BITS       = CNT_BITS + 1;

   localparam int CPR_BITS       = 16;
   localparam int PERIOD_BITS    = 16;
   localparam int GAIN_BITS      = 24;
   localparam int TIME_BITS      = 32;
   localparam int TOTAL_BITS     = 32;
   localparam int RPM_BITS       = 16;
   localparam int POS_BITS       = 40;
   localparam int FRAC_BITS      = 16;

   // speed arithmetic: delta * 60000 / (cpr * elapsed)
   localparam int MS_PER_MIN_BITS = 16;
   localparam logic [MS_PER_MIN_BITS-1:0] MS_PER_MIN = MS_PER_MIN_BITS'(60000);
   localparam int NUM_BITS       = MAG_BITS + MS_PER_MIN_BITS;
   localparam int DEN_BITS       = CPR_BITS + TIME_BITS;
   localparam int QUO_BITS       = RPM_BITS;
   localparam int PROD_BITS      = TOTAL_BITS + GAIN_BITS;

   localparam logic [QUO_BITS-1:0] Q_POS_LIMIT = QUO_BITS'((1 << (RPM_BITS - 1)) - 1);
   localparam logic [QUO_BITS-1:0] Q_NEG_LIMIT = QUO_BITS'(1 << (RPM_BITS - 1));
   localparam logic signed [RPM_BITS-1:0] RPM_MAX = RPM_BITS'((1 << (RPM_BITS - 1)) - 1);
   localparam logic signed [RPM_BITS-1:0] RPM_MIN = RPM_BITS'(1 << (RPM_BITS - 1));

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_RESET  = 1'b1;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNTS_PER_REV  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_PERIOD   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POSITION_GAIN   = 2'd2;

   localparam logic [CPR_BITS-1:0]    CPR_RESET    = CPR_BITS'(4096);
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(10);
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(65536);
   localparam logic [CNT_BITS-1:0]    CNT_MID      = CNT_BITS'(CNT_HALF_INT);

   typedef struct packed {
      logic                 kind;
      logic [CNT_BITS-1:0]  counter_value;
      logic [TIME_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [TOTAL_BITS-1:0] pulse_sum;
      logic signed [RPM_BITS-1:0]   shaft_rpm;
      logic                         speed_updated;
      logic signed [POS_BITS-1:0]   travel_mm;
   } rsp_type;

   // request into the speed unit
   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [MAG_BITS-1:0]  mag;
      logic [CPR_BITS-1:0]  cpr;
      logic [TIME_BITS-1:0] elapsed;
   } rpm_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [RPM_BITS-1:0] rpm;
   } rpm_rsp_type;

   // counter difference folded into the half range either side of zero
   function automatic logic signed [CNT_BITS:0] fold_delta(
      input logic [CNT_BITS-1:0] cur,
      input logic [CNT_BITS-1:0] base_cnt
   );
      logic signed [CNT_BITS:0] d;
      logic signed [CNT_BITS:0] half;
      half = $signed((CNT_BITS+1)'(CNT_HALF_INT));
      d    = $signed({1'b0, cur}) - $signed({1'b0, base_cnt});
      // adding or removing the full range both flip the top bit here
      if (d > half || d < -half) begin
         d[CNT_BITS] = ~d[CNT_BITS];
      end
      return d;
   endfunction

endpackage

[rtl/epst_rpm_unit.sv]
// ----------------------------------------------------------------------------
// epst_rpm_unit: bit-serial speed calculation
// Forms delta*60000 and cpr*elapsed with shift-add multipliers, one bit a
// cycle, then a restoring divide for the 16 quotient bits, then saturation.
// ----------------------------------------------------------------------------
module epst_rpm_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  epst_pkg::rpm_req_type  rpm_req,
   output epst_pkg::rpm_rsp_type  rpm_rsp
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_MUL  = 3'd1;
   localparam logic [2:0] PH_CHK  = 3'd2;
   localparam logic [2:0] PH_DIV  = 3'd3;
   localparam logic [2:0] PH_SAT  = 3'd4;

   localparam int STEP_BITS = $clog2(epst_pkg::QUO_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(epst_pkg::QUO_BITS - 1);
   localparam int NUM_HI_BITS = epst_pkg::NUM_BITS - epst_pkg::QUO_BITS;

   logic [2:0]                            phase_ff, phase_in;
   logic [STEP_BITS-1:0]                  step_ff, step_in;
   logic                                  done_ff, done_in;

   logic                                  neg_ff, neg_in;
   logic [epst_pkg::MAG_BITS-1:0]         mag_ff, mag_in;
   logic [epst_pkg::TIME_BITS-1:0]        elapsed_ff, elapsed_in;
   logic [epst_pkg::MS_PER_MIN_BITS-1:0]  kmul_ff, kmul_in;
   logic [epst_pkg::CPR_BITS-1:0]         cpr_ff, cpr_in;
   logic [epst_pkg::NUM_BITS-1:0]         num_ff, num_in;
   logic [epst_pkg::DEN_BITS-1:0]         den_ff, den_in;
   logic [epst_pkg::DEN_BITS-1:0]         rem_ff, rem_in;
   logic [epst_pkg::QUO_BITS-1:0]         nsh_ff, nsh_in;
   logic [epst_pkg::QUO_BITS-1:0]         q_ff, q_in;
   logic                                  sat_ff, sat_in;
   logic signed [epst_pkg::RPM_BITS-1:0]  rpm_ff, rpm_in;

   logic [epst_pkg::MAG_BITS:0]           num_sum;
   logic [epst_pkg::TIME_BITS:0]          den_sum;
   logic [epst_pkg::DEN_BITS+1:0]         trial;
   logic [NUM_HI_BITS-1:0]                num_hi;
   logic                                  ovf;

   always_comb begin
      num_sum = {1'b0, num_ff[epst_pkg::NUM_BITS-1:epst_pkg::MS_PER_MIN_BITS]}
              + (kmul_ff[0] ? {1'b0, mag_ff} : '0);
      den_sum = {1'b0, den_ff[epst_pkg::DEN_BITS-1:epst_pkg::CPR_BITS]}
              + (cpr_ff[0] ? {1'b0, elapsed_ff} : '0);
      trial   = {1'b0, rem_ff, nsh_ff[epst_pkg::QUO_BITS-1]} - {2'b00, den_ff};
      num_hi  = num_ff[epst_pkg::NUM_BITS-1:epst_pkg::QUO_BITS];
      // quotient reaches 2^16 when the top of the numerator is not below den
      ovf     = (den_ff[epst_pkg::DEN_BITS-1:NUM_HI_BITS] == '0)
             && (num_hi >= den_ff[NUM_HI_BITS-1:0]);
   end

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      elapsed_in = elapsed_ff;
      kmul_in    = kmul_ff;
      cpr_in     = cpr_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      nsh_in     = nsh_ff;
      q_in       = q_ff;
      sat_in     = sat_ff;
      rpm_in     = rpm_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (rpm_req.start) begin
               neg_in     = rpm_req.neg;
               mag_in     = rpm_req.mag;
               elapsed_in = rpm_req.elapsed;
               cpr_in     = rpm_req.cpr;
               kmul_in    = epst_pkg::MS_PER_MIN;
               num_in     = '0;
               den_in     = '0;
               step_in    = '0;
               phase_in   = PH_MUL;
            end
         end
         PH_MUL: begin
            num_in  = {num_sum, num_ff[epst_pkg::MS_PER_MIN_BITS-1:1]};
            den_in  = {den_sum, den_ff[epst_pkg::CPR_BITS-1:1]};
            kmul_in = kmul_ff >> 1;
            cpr_in  = cpr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            sat_in   = ovf;
            rem_in   = epst_pkg::DEN_BITS'(num_hi);
            nsh_in   = num_ff[epst_pkg::QUO_BITS-1:0];
            q_in     = '0;
            step_in  = '0;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            if (!trial[epst_pkg::DEN_BITS+1]) begin
               rem_in = trial[epst_pkg::DEN_BITS-1:0];
            end else begin
               rem_in = {rem_ff[epst_pkg::DEN_BITS-2:0], nsh_ff[epst_pkg::QUO_BITS-1]};
            end
            q_in    = {q_ff[epst_pkg::QUO_BITS-2:0], ~trial[epst_pkg::DEN_BITS+1]};
            nsh_in  = nsh_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               phase_in = PH_SAT;
            end
         end
         PH_SAT: begin
            if (neg_ff) begin
               rpm_in = (sat_ff || q_ff > epst_pkg::Q_NEG_LIMIT)
                      ? epst_pkg::RPM_MIN : $signed(epst_pkg::RPM_BITS'(-q_ff));
            end else begin
               rpm_in = (sat_ff || q_ff > epst_pkg::Q_POS_LIMIT)
                      ? epst_pkg::RPM_MAX : $signed(q_ff);
            end
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      elapsed_ff <= elapsed_in;
      kmul_ff    <= kmul_in;
      cpr_ff     <= cpr_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      nsh_ff     <= nsh_in;
      q_ff       <= q_in;
      sat_ff     <= sat_in;
      rpm_ff     <= rpm_in;
   end

   assign rpm_rsp.done = done_ff;
   assign rpm_rsp.rpm  = rpm_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      rpm_req.start |-> phase_ff == PH_IDLE)
      else $error("speed unit started while busy");

   a_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_IDLE && $past(phase_ff) == PH_SAT)
      else $error("speed result without saturation step");

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      done_ff && sat_ff |-> rpm_ff == epst_pkg::RPM_MAX || rpm_ff == epst_pkg::RPM_MIN)
      else $error("overflowing quotient not clamped");

endmodule

[rtl/encoder_position_speed_tracker.sv]
// ----------------------------------------------------------------------------
// encoder_position_speed_tracker: quadrature count, position and speed
// Unwraps raw encoder counter samples into a 32-bit total, reports position
// as total*gain with the gain in Q16, and speed in RPM once the sample period has passed.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sample (kind 0) or tracking reset (kind 1) per transfer.
//   rsp_*  : one result per request, in request order.
//   csr_*  : counts_per_rev, sample_period_ms and position_gain; write only
//            while no request is in flight.
// Each request runs from acceptance to the result appearing on rsp_valid
// through a bit-serial multiply for delta*60000 and cpr*elapsed, an
// overflow check, a restoring divide (one quotient bit a cycle), a
// saturation step, the registered hand-back of the speed and the load of
// the output register. The next request can be taken the cycle after that
// load.
// The position multiply runs alongside, one gain bit a cycle.
// A new request is taken once the previous one has been handed to the output
// register, so a result may wait on rsp_ready while the next sample works.
// When the output register is still full at the end, the block holds the
// finished result and keeps req_ready low until the receiver takes the
// previous transfer. Reset restores the register defaults, clears the totals
// and speed, and sets both reference counts to the counter midpoint.
// ----------------------------------------------------------------------------
module encoder_position_speed_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  epst_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output epst_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [epst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [epst_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   localparam int POS_CNT_BITS = $clog2(epst_pkg::GAIN_BITS + 1);
   localparam logic [POS_CNT_BITS-1:0] POS_STEPS = POS_CNT_BITS'(epst_pkg::GAIN_BITS);
   localparam int PHI = epst_pkg::PROD_BITS - epst_pkg::GAIN_BITS;

   logic [1:0]                              state_ff, state_in;
   logic [epst_pkg::CPR_BITS-1:0]           cpr_ff;
   logic [epst_pkg::PERIOD_BITS-1:0]        period_ff;
   logic [epst_pkg::GAIN_BITS-1:0]          gain_ff;

   logic signed [epst_pkg::TOTAL_BITS-1:0]  acc_ff, acc_in;
   logic [epst_pkg::CNT_BITS-1:0]           prev_ff, prev_in;
   logic [epst_pkg::CNT_BITS-1:0]           sref_ff, sref_in;
   logic [epst_pkg::TIME_BITS-1:0]          last_ff, last_in;
   logic signed [epst_pkg::RPM_BITS-1:0]    held_ff, held_in;
   logic                                    upd_ff, upd_in;

   logic [POS_CNT_BITS-1:0]                 pos_cnt_ff, pos_cnt_in;
   logic [epst_pkg::PROD_BITS-1:0]          pacc_ff, pacc_in;
   logic [epst_pkg::GAIN_BITS-1:0]          gsh_ff, gsh_in;

   logic                                    rsp_valid_ff, rsp_valid_in;
   epst_pkg::rsp_type                       rsp_data_ff, rsp_data_in;

   logic                                    req_fire;
   logic                                    rsp_load;
   logic signed [epst_pkg::CNT_BITS:0]      d_pos;
   logic signed [epst_pkg::CNT_BITS:0]      d_spd;
   logic [epst_pkg::TIME_BITS-1:0]          elapsed;
   logic                                    upd_now;
   logic [PHI:0]                            psum;
   epst_pkg::rpm_req_type                   rpm_req;
   epst_pkg::rpm_rsp_type                   rpm_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      d_pos   = epst_pkg::fold_delta(req_data.counter_value, prev_ff);
      d_spd   = epst_pkg::fold_delta(req_data.counter_value, sref_ff);
      elapsed = req_data.now_ms - last_ff;
      upd_now = (elapsed >= epst_pkg::TIME_BITS'(period_ff)) && (elapsed != '0);

      rpm_req.start   = req_fire;
      rpm_req.neg     = d_spd[epst_pkg::CNT_BITS];
      rpm_req.mag     = d_spd[epst_pkg::CNT_BITS] ? epst_pkg::MAG_BITS'(-d_spd)
                                                  : epst_pkg::MAG_BITS'(d_spd);
      rpm_req.cpr     = (cpr_ff == '0) ? epst_pkg::CPR_BITS'(1) : cpr_ff;
      rpm_req.elapsed = elapsed;
   end

   // signed shift-add: multiplicand is the running total, one gain bit a cycle
   assign psum = {pacc_ff[epst_pkg::PROD_BITS-1], pacc_ff[epst_pkg::PROD_BITS-1:
                  epst_pkg::GAIN_BITS]}
               + (gsh_ff[0] ? {acc_ff[epst_pkg::TOTAL_BITS-1], acc_ff} : '0);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      sref_in      = sref_ff;
      last_in      = last_ff;
      held_in      = held_ff;
      upd_in       = upd_ff;
      pos_cnt_in   = pos_cnt_ff;
      pacc_in      = pacc_ff;
      gsh_in       = gsh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pacc_in    = '0;
               gsh_in     = gain_ff;
               pos_cnt_in = '0;
               state_in   = ST_RUN;
               if (req_data.kind == epst_pkg::KIND_RESET) begin
                  acc_in  = '0;
                  prev_in = epst_pkg::CNT_MID;
                  sref_in = epst_pkg::CNT_MID;
                  last_in = req_data.now_ms;
                  held_in = '0;
                  upd_in  = 1'b0;
               end else begin
                  acc_in  = acc_ff + epst_pkg::TOTAL_BITS'(d_pos);
                  prev_in = req_data.counter_value;
                  upd_in  = upd_now;
                  if (upd_now) begin
                     sref_in = req_data.counter_value;
                     last_in = req_data.now_ms;
                  end
               end
            end
         end
         ST_RUN: begin
            if (pos_cnt_ff != POS_STEPS) begin
               pacc_in    = {psum, pacc_ff[epst_pkg::GAIN_BITS-1:1]};
               gsh_in     = gsh_ff >> 1;
               pos_cnt_in = pos_cnt_ff + 1'b1;
            end
            if (rpm_rsp.done) begin
               if (upd_ff) begin
                  held_in = rpm_rsp.rpm;
               end
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pulse_sum     = acc_ff;
               rsp_data_in.shaft_rpm     = held_ff;
               rsp_data_in.speed_updated = upd_ff;
               // arithmetic shift of the product gives the floor of p/2^16
               rsp_data_in.travel_mm     = $signed(pacc_ff[epst_pkg::PROD_BITS-1:
                                                   epst_pkg::FRAC_BITS]);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff    <= epst_pkg::CPR_RESET;
         period_ff <= epst_pkg::PERIOD_RESET;
         gain_ff   <= epst_pkg::GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            epst_pkg::CSR_COUNTS_PER_REV: begin
               cpr_ff <= csr_wdata[epst_pkg::CPR_BITS-1:0];
            end
            epst_pkg::CSR_SAMPLE_PERIOD: begin
               period_ff <= csr_wdata[epst_pkg::PERIOD_BITS-1:0];
            end
            epst_pkg::CSR_POSITION_GAIN: begin
               gain_ff <= csr_wdata[epst_pkg::GAIN_BITS-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         prev_ff      <= epst_pkg::CNT_MID;
         sref_ff      <= epst_pkg::CNT_MID;
         last_ff      <= '0;
         held_ff      <= '0;
         upd_ff       <= 1'b0;
         pos_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
         sref_ff      <= sref_in;
         last_ff      <= last_in;
         held_ff      <= held_in;
         upd_ff       <= upd_in;
         pos_cnt_ff   <= pos_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pacc_ff     <= pacc_in;
      gsh_ff      <= gsh_in;
      rsp_data_ff <= rsp_data_in;
   end

   epst_rpm_unit u_rpm (
      .clock   (clock),
      .reset   (reset),
      .rpm_req (rpm_req),
      .rpm_rsp (rpm_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_reset_item_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.kind == epst_pkg::KIND_RESET
      |=> acc_ff == '0 && held_ff == '0 && !upd_ff)
      else $error("tracking reset did not clear totals");

   a_speed_done_in_run: assert property (@(posedge clock) disable iff (reset)
      rpm_rsp.done |-> state_ff == ST_RUN)
      else $error("speed result outside the run phase");

   a_position_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> pos_cnt_ff == POS_STEPS)
      else $error("result loaded before position multiply finished");

   a_held_follows_update: assert property (@(posedge clock) disable iff (reset)
      rpm_rsp.done && upd_ff |=> held_ff == $past(rpm_rsp.rpm))
      else $error("held speed not updated");

endmodule
